FILE: rtl/uvs_pkg.sv
// Package for the UV sphere vertex generator: sizes, item types, register indexes,
// divisor reciprocal tables and the quarter-wave sine table builder.
// No dependencies.
`timescale 1ns / 1ps

package uvs_pkg;

  localparam int MAX_STEPS        = 64;
  localparam int MIN_STEPS        = 4;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int IDX_W  = 16;
  localparam int RAD_W  = 16;
  localparam int N_W    = 7;
  localparam int CFG_W  = 16;
  localparam int POS_W  = 17;
  localparam int TEX_W  = 17;
  localparam int NRM_W  = 16;
  localparam int QS_W   = 17;
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PH_W   = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int R_W    = $clog2(MAX_STEPS + 2);
  localparam int C_W    = $clog2(2 * MAX_STEPS + 1);
  localparam int DIV_W  = $clog2(4 * MAX_STEPS + 1);
  localparam int TEX_SCALE = 131072;
  localparam int NUM_W  = $clog2(TEX_SCALE * 2 * MAX_STEPS + 2 * MAX_STEPS + 1);
  localparam int QUO_W  = 17;
  localparam int RECIP_K = 32;
  localparam int LATENCY = 15;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(256);
  localparam logic [N_W-1:0]   STEPS_RESET  = N_W'(16);

  localparam logic [0:0] REG_RADIUS = 1'd0;
  localparam logic [0:0] REG_STEPS  = 1'd1;

  typedef enum logic [1:0] {
    REGION_TOP,
    REGION_BAND,
    REGION_BOTTOM
  } region_t;

  typedef struct packed {
    logic           oor;
    logic           fin;
    logic [N_W-1:0] n;
    logic [R_W-1:0] r;
    logic [C_W-1:0] c;
  } vtx_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [RECIP_K-1:0] recip_tab_t [0:MAX_STEPS];
  typedef logic [IDX_W-1:0]   total_tab_t [0:MAX_STEPS];
  typedef logic [QS_W-1:0]    sine_rom_t  [0:SINE_TABLE_DEPTH];

  // floor(2^32 / div), by restoring long division
  function automatic logic [RECIP_K-1:0] recip_of(input logic [15:0] div);
    logic [RECIP_K:0] rem;
    logic [RECIP_K:0] q;
    rem = '0;
    q   = '0;
    for (int i = RECIP_K; i >= 0; i--) begin
      rem = {rem[RECIP_K-1:0], (i == RECIP_K)};
      if (rem >= (RECIP_K+1)'(div)) begin
        rem  = rem - (RECIP_K+1)'(div);
        q[i] = 1'b1;
      end
    end
    return q[RECIP_K-1:0];
  endfunction

  // reciprocal of (mul*N + add) for every N, N clamped up to the minimum
  function automatic recip_tab_t build_recip(input int mul, input int add);
    recip_tab_t t;
    int nn;
    for (int n = 0; n <= MAX_STEPS; n++) begin
      nn   = (n < MIN_STEPS) ? MIN_STEPS : n;
      t[n] = recip_of(16'(mul * nn + add));
    end
    return t;
  endfunction

  function automatic total_tab_t build_total();
    total_tab_t t;
    int nn;
    for (int n = 0; n <= MAX_STEPS; n++) begin
      nn   = (n < MIN_STEPS) ? MIN_STEPS : n;
      t[n] = IDX_W'(12 * nn * nn);
    end
    return t;
  endfunction

  localparam recip_tab_t RECIP_12N  = build_recip(12, 0);
  localparam recip_tab_t RECIP_2N   = build_recip(2, 0);
  localparam recip_tab_t RECIP_4N   = build_recip(4, 0);
  localparam recip_tab_t RECIP_2NP2 = build_recip(2, 2);
  localparam total_tab_t TOTAL_TAB  = build_total();

  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam longint unsigned SINE_DEN = 64'(2 * SINE_TABLE_DEPTH);
  localparam longint unsigned TAYLOR_DIV [1:10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // quarter-wave sine in Q1.16, Taylor series in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned x, x2, term, sum, e, kk;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      kk   = 64'(k);
      x    = (kk * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / SINE_DEN;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      e = (sum + 64'd8192) >> 14;
      if (e > 64'd65536) begin
        e = 64'd65536;
      end
      rom[k] = QS_W'(e);
    end
    return rom;
  endfunction

endpackage

FILE: rtl/uvs_front.sv
// Front part: decodes a vertex index into ring, column and range flags.
// Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [uvs_pkg::IDX_W-1:0]   in_index,
  input  logic [uvs_pkg::N_W-1:0]     step_count,
  output logic                        out_valid,
  output uvs_pkg::vtx_item_t          out_item
);

  localparam int IDX_W = uvs_pkg::IDX_W;
  localparam int N_W   = uvs_pkg::N_W;
  localparam int R_W   = uvs_pkg::R_W;
  localparam int C_W   = uvs_pkg::C_W;
  localparam int K     = uvs_pkg::RECIP_K;
  localparam int D12_W = $clog2(12 * uvs_pkg::MAX_STEPS + 1);
  localparam int M_W   = IDX_W - 1;
  localparam logic [IDX_W-1:0] DIV3_MUL = IDX_W'(43691);
  localparam int DIV3_SH = 17;

  logic [5:1] v;

  // stage 1: capture
  logic [IDX_W-1:0] idx1;
  logic [N_W-1:0]   n1;

  // stage 2: range and region
  logic [IDX_W-1:0] total, cap, bot_base, rem;
  uvs_pkg::region_t region;
  logic [IDX_W-1:0] rem2;
  logic [N_W-1:0]   n2;
  logic             oor2, fin2;
  uvs_pkg::region_t region2;

  // stage 3: band quotient estimate
  logic [IDX_W+K-1:0] prod3;
  logic [R_W-1:0]     q3;
  logic [IDX_W-1:0]   rem3;
  logic [N_W-1:0]     n3;
  logic               oor3, fin3;
  uvs_pkg::region_t   region3;

  // stage 4: correct quotient
  logic [D12_W-1:0]     d12;
  logic [R_W+D12_W-1:0] qd;
  logic [IDX_W-1:0]     rr, x;
  logic [R_W-1:0]       bq;
  logic [IDX_W-1:0]     x4;
  logic [R_W-1:0]       band4;
  logic [N_W-1:0]       n4;
  logic                 oor4, fin4;
  uvs_pkg::region_t     region4;

  // stage 5: divide by three
  logic [2*IDX_W-1:0] prod5;
  logic [M_W-1:0]     m5;
  logic [IDX_W-1:0]   x5;
  logic [R_W-1:0]     band5;
  logic [N_W-1:0]     n5;
  logic               oor5, fin5;
  uvs_pkg::region_t   region5;

  // stage 6: corner select
  logic [IDX_W-1:0] mm, mul;
  logic [2:0]       k;
  logic [R_W-1:0]   r6;
  logic [C_W-1:0]   cm, cm1;

  always_comb begin
    total    = uvs_pkg::TOTAL_TAB[n1];
    cap      = IDX_W'(n1) * IDX_W'(6);
    bot_base = total - cap;
    if (idx1 < cap) begin
      region = uvs_pkg::REGION_TOP;
      rem    = idx1;
    end else if (idx1 < bot_base) begin
      region = uvs_pkg::REGION_BAND;
      rem    = idx1 - cap;
    end else begin
      region = uvs_pkg::REGION_BOTTOM;
      rem    = idx1 - bot_base;
    end
  end

  assign prod3 = (IDX_W+K)'(rem2) * (IDX_W+K)'(uvs_pkg::RECIP_12N[n2]);

  always_comb begin
    d12 = D12_W'(n3) * D12_W'(12);
    qd  = (R_W+D12_W)'(q3) * (R_W+D12_W)'(d12);
    rr  = rem3 - IDX_W'(qd);
    bq  = q3;
    x   = rem3;
    if (region3 == uvs_pkg::REGION_BAND) begin
      x = rr;
      if (rr >= IDX_W'(d12)) begin
        bq = q3 + R_W'(1);
        x  = rr - IDX_W'(d12);
      end
    end
  end

  assign prod5 = (2*IDX_W)'(x4) * (2*IDX_W)'(DIV3_MUL);

  always_comb begin
    if (region5 == uvs_pkg::REGION_BAND) begin
      mm  = IDX_W'(m5 >> 1);
      mul = mm * IDX_W'(6);
    end else begin
      mm  = IDX_W'(m5);
      mul = mm * IDX_W'(3);
    end
    k   = 3'(x5 - mul);
    cm  = C_W'(mm);
    cm1 = C_W'(mm + IDX_W'(1));
    r6  = band5;
    case (region5)
      uvs_pkg::REGION_TOP: begin
        r6 = R_W'(1);
        case (k)
          3'd0:    begin r6 = R_W'(1); end
          3'd1:    begin r6 = R_W'(1); cm = cm1; end
          default: begin r6 = R_W'(0); end
        endcase
      end
      uvs_pkg::REGION_BAND: begin
        case (k)
          3'd0:        begin r6 = band5; end
          3'd1:        begin r6 = band5 + R_W'(1); end
          3'd2, 3'd3:  begin r6 = band5 + R_W'(1); cm = cm1; end
          3'd4:        begin r6 = band5; cm = cm1; end
          default:     begin r6 = band5; end
        endcase
      end
      default: begin
        case (k)
          3'd0:    begin r6 = R_W'(n5) + R_W'(1); cm = cm1; end
          3'd1:    begin r6 = R_W'(n5); cm = cm1; end
          default: begin r6 = R_W'(n5); end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      v         <= {v[4:1], in_valid};
      out_valid <= v[5];
    end
    idx1 <= in_index;
    n1   <= step_count;

    rem2    <= rem;
    n2      <= n1;
    oor2    <= (idx1 >= total);
    fin2    <= (idx1 == total - IDX_W'(1));
    region2 <= region;

    q3      <= prod3[K +: R_W];
    rem3    <= rem2;
    n3      <= n2;
    oor3    <= oor2;
    fin3    <= fin2;
    region3 <= region2;

    x4      <= x;
    band4   <= bq + R_W'(1);
    n4      <= n3;
    oor4    <= oor3;
    fin4    <= fin3;
    region4 <= region3;

    m5      <= prod5[DIV3_SH +: M_W];
    x5      <= x4;
    band5   <= band4;
    n5      <= n4;
    oor5    <= oor4;
    fin5    <= fin4;
    region5 <= region4;

    out_item.oor <= oor5;
    out_item.fin <= fin5;
    out_item.n   <= n5;
    out_item.r   <= r6;
    out_item.c   <= cm;
  end

endmodule

FILE: rtl/uvs_queue.sv
// Two-entry item queue between the decode front and the compute back.
// Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  uvs_pkg::vtx_item_t push_item,
  input  logic               pop,
  output uvs_pkg::vtx_item_t head,
  output uvs_pkg::q_status_t status
);

  localparam int QDEPTH = 2;
  localparam int P_W    = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  uvs_pkg::vtx_item_t slots [QDEPTH];
  logic [P_W-1:0]     wp, rp;
  logic [CNT_W-1:0]   cnt;
  logic               do_pop;

  assign do_pop       = pop && (cnt != '0);
  assign head         = slots[rp];
  assign status.empty = (cnt == '0);
  assign status.full  = (cnt == CNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + P_W'(1);
      end
      if (do_pop) begin
        rp <= rp + P_W'(1);
      end
      cnt <= cnt + CNT_W'(push) - CNT_W'(do_pop);
    end
    if (push) begin
      slots[wp] <= push_item;
    end
  end

endmodule

FILE: rtl/uvs_sine_rom.sv
// Quarter-wave sine table, two registered read ports.
// Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_sine_rom (
  input  logic                       clk,
  input  logic [uvs_pkg::ADDR_W-1:0] addr_a,
  input  logic [uvs_pkg::ADDR_W-1:0] addr_b,
  output logic [uvs_pkg::QS_W-1:0]   data_a,
  output logic [uvs_pkg::QS_W-1:0]   data_b
);

  localparam uvs_pkg::sine_rom_t SINE = uvs_pkg::build_sine_rom();

  always_ff @(posedge clk) begin
    data_a <= SINE[addr_a];
    data_b <= SINE[addr_b];
  end

endmodule

FILE: rtl/uvs_back.sv
// Back part: phases, texture, sine lookups, products and rounding.
// Depends on uvs_pkg and uvs_sine_rom.
`timescale 1ns / 1ps

module uvs_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  uvs_pkg::vtx_item_t               in_item,
  input  logic [uvs_pkg::RAD_W-1:0]        radius,
  output logic                             done,
  output logic signed [uvs_pkg::POS_W-1:0] pos_x,
  output logic signed [uvs_pkg::POS_W-1:0] pos_y,
  output logic signed [uvs_pkg::POS_W-1:0] pos_z,
  output logic [uvs_pkg::TEX_W-1:0]        tex_s,
  output logic [uvs_pkg::TEX_W-1:0]        tex_t,
  output logic signed [uvs_pkg::NRM_W-1:0] norm_x,
  output logic signed [uvs_pkg::NRM_W-1:0] norm_y,
  output logic signed [uvs_pkg::NRM_W-1:0] norm_z,
  output logic                             index_out_of_range,
  output logic                             final_vertex
);

  localparam int NL    = 4;
  localparam int L_PA  = 0;
  localparam int L_PB  = 1;
  localparam int L_TS  = 2;
  localparam int L_TT  = 3;
  localparam int D     = uvs_pkg::SINE_TABLE_DEPTH;
  localparam int NUM_W = uvs_pkg::NUM_W;
  localparam int DIV_W = uvs_pkg::DIV_W;
  localparam int QUO_W = uvs_pkg::QUO_W;
  localparam int K     = uvs_pkg::RECIP_K;
  localparam int PH_W  = uvs_pkg::PH_W;
  localparam int ADDR_W = uvs_pkg::ADDR_W;
  localparam int QS_W  = uvs_pkg::QS_W;
  localparam int RAD_W = uvs_pkg::RAD_W;
  localparam int POS_W = uvs_pkg::POS_W;
  localparam int NRM_W = uvs_pkg::NRM_W;
  localparam int TEX_W = uvs_pkg::TEX_W;
  localparam int RS_W  = RAD_W + QS_W;
  localparam int SS_W  = 2 * QS_W;
  localparam int PP_W  = RS_W + QS_W;
  localparam logic [NRM_W-2:0] NRM_MAX = '1;

  typedef struct packed {
    logic              neg;
    logic [ADDR_W-1:0] addr;
  } trig_ref_t;

  typedef struct packed {
    logic             oor;
    logic             fin;
    logic             nsa, nca, nsb, ncb;
    logic [TEX_W-1:0] ts;
    logic [TEX_W-1:0] tt;
  } side_t;

  function automatic trig_ref_t fold(input logic [PH_W-1:0] p);
    trig_ref_t  t;
    logic [PH_W:0] pp;
    pp = {1'b0, p};
    if (pp <= (PH_W+1)'(D)) begin
      t.neg  = 1'b0;
      t.addr = ADDR_W'(pp);
    end else if (pp <= (PH_W+1)'(2 * D)) begin
      t.neg  = 1'b0;
      t.addr = ADDR_W'((PH_W+1)'(2 * D) - pp);
    end else if (pp <= (PH_W+1)'(3 * D)) begin
      t.neg  = 1'b1;
      t.addr = ADDR_W'(pp - (PH_W+1)'(2 * D));
    end else begin
      t.neg  = 1'b1;
      t.addr = ADDR_W'((PH_W+1)'(4 * D) - pp);
    end
    return t;
  endfunction

  logic [6:0] v;
  logic [1:0] tag0, tag1, tag2;

  // stage 0: item from the queue
  uvs_pkg::vtx_item_t item0;

  // stage 1: numerators, divisors, quotient estimates
  logic [NUM_W-1:0]   num  [NL];
  logic [DIV_W-1:0]   dv   [NL];
  logic [K-1:0]       rcp  [NL];
  logic [NUM_W+K-1:0] prod [NL];
  logic [NUM_W-1:0]   num1 [NL];
  logic [DIV_W-1:0]   dv1  [NL];
  logic [QUO_W-1:0]   qe1  [NL];

  // stage 2: corrected quotients
  logic [QUO_W+DIV_W-1:0] qd [NL];
  logic [NUM_W-1:0]       rr [NL];
  logic [QUO_W-1:0]       q2 [NL];

  // stage 3: fold phases into table addresses
  trig_ref_t ref_sa, ref_ca, ref_sb, ref_cb;
  logic [PH_W-1:0] ph_a, ph_b;
  trig_ref_t a_sa, a_ca, a_sb, a_cb;
  side_t side3, side4, side5, side6;

  // stage 4: table data
  logic [QS_W-1:0] sa4, ca4, sb4, cb4;

  // stage 5: first products
  logic [RS_W-1:0] rsa5, rca5;
  logic [SS_W-1:0] ssb5, scb5;
  logic [QS_W-1:0] sb5, cb5, ca5;

  // stage 6: second products, rounding of the short terms
  logic [PP_W-1:0]    px6, pz6;
  logic [POS_W-1:0]   py6;
  logic [NRM_W-2:0]   nx6, ny6, nz6;
  logic [SS_W-1:0]    nxr, nzr;
  logic [RS_W-1:0]    pyr;
  logic [QS_W-1:0]    nyr;

  // stage 7: rounding and sign
  logic [PP_W-1:0]  pxr, pzr;
  logic [POS_W-1:0] pxm, pzm;

  always_comb begin
    num[L_PA] = NUM_W'(item0.r) * NUM_W'(4 * D) + NUM_W'(item0.n) + NUM_W'(1);
    dv[L_PA]  = DIV_W'({item0.n, 1'b0}) + DIV_W'(2);
    rcp[L_PA] = uvs_pkg::RECIP_2NP2[item0.n];
    num[L_PB] = NUM_W'(item0.c) * NUM_W'(4 * D) + NUM_W'(item0.n);
    dv[L_PB]  = DIV_W'({item0.n, 1'b0});
    rcp[L_PB] = uvs_pkg::RECIP_2N[item0.n];
    num[L_TS] = NUM_W'(item0.c) * NUM_W'(uvs_pkg::TEX_SCALE) + NUM_W'({item0.n, 1'b0});
    dv[L_TS]  = DIV_W'({item0.n, 2'b00});
    rcp[L_TS] = uvs_pkg::RECIP_4N[item0.n];
    num[L_TT] = NUM_W'(item0.r) * NUM_W'(uvs_pkg::TEX_SCALE) + NUM_W'(item0.n) + NUM_W'(1);
    dv[L_TT]  = DIV_W'({item0.n, 1'b0}) + DIV_W'(2);
    rcp[L_TT] = uvs_pkg::RECIP_2NP2[item0.n];
    for (int l = 0; l < NL; l++) begin
      prod[l] = (NUM_W+K)'(num[l]) * (NUM_W+K)'(rcp[l]);
    end
  end

  // estimate is low by at most one: one compare and step fixes it
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      qd[l] = (QUO_W+DIV_W)'(qe1[l]) * (QUO_W+DIV_W)'(dv1[l]);
      rr[l] = num1[l] - NUM_W'(qd[l]);
    end
  end

  always_comb begin
    ph_a   = q2[L_PA][PH_W-1:0];
    ph_b   = q2[L_PB][PH_W-1:0];
    ref_sa = fold(ph_a);
    ref_ca = fold(ph_a + PH_W'(D));
    ref_sb = fold(ph_b);
    ref_cb = fold(ph_b + PH_W'(D));
  end

  uvs_sine_rom u_rom_a (
    .clk    (clk),
    .addr_a (a_sa.addr),
    .addr_b (a_ca.addr),
    .data_a (sa4),
    .data_b (ca4)
  );

  uvs_sine_rom u_rom_b (
    .clk    (clk),
    .addr_a (a_sb.addr),
    .addr_b (a_cb.addr),
    .data_a (sb4),
    .data_b (cb4)
  );

  always_comb begin
    nxr = (ssb5 + SS_W'(65536)) >> 17;
    nzr = (scb5 + SS_W'(65536)) >> 17;
    pyr = (rca5 + RS_W'(32768)) >> 16;
    nyr = (ca5 + QS_W'(1)) >> 1;
    pxr = (px6 + PP_W'(64'h8000_0000)) >> 32;
    pzr = (pz6 + PP_W'(64'h8000_0000)) >> 32;
    pxm = POS_W'(pxr);
    pzm = POS_W'(pzr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[5:0], in_valid};
      done <= v[6];
    end

    item0 <= in_item;
    tag0  <= {in_item.oor, in_item.fin};

    for (int l = 0; l < NL; l++) begin
      num1[l] <= num[l];
      dv1[l]  <= dv[l];
      qe1[l]  <= prod[l][K +: QUO_W];
      q2[l]   <= (rr[l] >= NUM_W'(dv1[l])) ? qe1[l] + QUO_W'(1) : qe1[l];
    end
    tag1 <= tag0;
    tag2 <= tag1;

    a_sa      <= ref_sa;
    a_ca      <= ref_ca;
    a_sb      <= ref_sb;
    a_cb      <= ref_cb;
    side3.oor <= tag2[1];
    side3.fin <= tag2[0];
    side3.nsa <= ref_sa.neg;
    side3.nca <= ref_ca.neg;
    side3.nsb <= ref_sb.neg;
    side3.ncb <= ref_cb.neg;
    side3.ts  <= TEX_W'(q2[L_TS]);
    side3.tt  <= TEX_W'(q2[L_TT]);
    side4     <= side3;

    rsa5  <= RS_W'(radius) * RS_W'(sa4);
    rca5  <= RS_W'(radius) * RS_W'(ca4);
    ssb5  <= SS_W'(sa4) * SS_W'(sb4);
    scb5  <= SS_W'(sa4) * SS_W'(cb4);
    sb5   <= sb4;
    cb5   <= cb4;
    ca5   <= ca4;
    side5 <= side4;

    px6   <= PP_W'(rsa5) * PP_W'(sb5);
    pz6   <= PP_W'(rsa5) * PP_W'(cb5);
    py6   <= POS_W'(pyr);
    nx6   <= (nxr > SS_W'(NRM_MAX)) ? NRM_MAX : (NRM_W-1)'(nxr);
    nz6   <= (nzr > SS_W'(NRM_MAX)) ? NRM_MAX : (NRM_W-1)'(nzr);
    ny6   <= (nyr > QS_W'(NRM_MAX)) ? NRM_MAX : (NRM_W-1)'(nyr);
    side6 <= side5;

    // out-of-range items give zeros and the flag alone
    index_out_of_range <= side6.oor;
    if (side6.oor) begin
      pos_x        <= '0;
      pos_y        <= '0;
      pos_z        <= '0;
      tex_s        <= '0;
      tex_t        <= '0;
      norm_x       <= '0;
      norm_y       <= '0;
      norm_z       <= '0;
      final_vertex <= 1'b0;
    end else begin
      pos_x        <= (side6.nsa ^ side6.nsb) ? -$signed(pxm) : $signed(pxm);
      pos_y        <= side6.nca ? -$signed(py6) : $signed(py6);
      pos_z        <= (side6.nsa ^ side6.ncb) ? -$signed(pzm) : $signed(pzm);
      tex_s        <= side6.ts;
      tex_t        <= side6.tt;
      norm_x       <= (side6.nsa ^ side6.nsb) ? -$signed({1'b0, nx6}) : $signed({1'b0, nx6});
      norm_y       <= side6.nca ? -$signed({1'b0, ny6}) : $signed({1'b0, ny6});
      norm_z       <= (side6.nsa ^ side6.ncb) ? -$signed({1'b0, nz6}) : $signed({1'b0, nz6});
      final_vertex <= side6.fin;
    end
  end

endmodule

FILE: rtl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: one vertex per cycle while busy is low.
// Throughput is one item per cycle; the rate is set by the back pipeline, which
// runs four reciprocal dividers and two dual-port sine tables in every cycle.
// Synchronous reset clears both pipelines, the queue and the registers to
// radius 256 and 16 steps; busy is high for the cycle after reset.
// The receiver cannot stall: each result shows on done for exactly one cycle.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [uvs_pkg::IDX_W-1:0]        vertex_index,
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]        cfg_data,
  output logic                             done,
  output logic signed [uvs_pkg::POS_W-1:0] pos_x,
  output logic signed [uvs_pkg::POS_W-1:0] pos_y,
  output logic signed [uvs_pkg::POS_W-1:0] pos_z,
  output logic [uvs_pkg::TEX_W-1:0]        tex_s,
  output logic [uvs_pkg::TEX_W-1:0]        tex_t,
  output logic signed [uvs_pkg::NRM_W-1:0] norm_x,
  output logic signed [uvs_pkg::NRM_W-1:0] norm_y,
  output logic signed [uvs_pkg::NRM_W-1:0] norm_z,
  output logic                             index_out_of_range,
  output logic                             final_vertex
);

  localparam int N_W = uvs_pkg::N_W;

  logic [uvs_pkg::RAD_W-1:0] sphere_radius;
  logic [N_W-1:0]            step_count;
  logic [N_W-1:0]            steps_in;
  logic [N_W-1:0]            steps_next;
  logic                      accept;

  logic                 f_valid;
  uvs_pkg::vtx_item_t   f_item;
  uvs_pkg::vtx_item_t   q_head;
  uvs_pkg::q_status_t   q_stat;
  logic                 q_pop;

  assign accept = start && !busy;

  // clamp step writes into the supported range
  always_comb begin
    steps_in   = cfg_data[N_W-1:0];
    steps_next = steps_in;
    if (steps_in < N_W'(uvs_pkg::MIN_STEPS)) begin
      steps_next = N_W'(uvs_pkg::MIN_STEPS);
    end else if (steps_in > N_W'(uvs_pkg::MAX_STEPS)) begin
      steps_next = N_W'(uvs_pkg::MAX_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= uvs_pkg::RADIUS_RESET;
      step_count    <= uvs_pkg::STEPS_RESET;
      busy          <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          uvs_pkg::REG_RADIUS: sphere_radius <= cfg_data;
          uvs_pkg::REG_STEPS:  step_count    <= steps_next;
          default: ;
        endcase
      end
    end
  end

  // front: index decode to ring and column
  uvs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .in_index   (vertex_index),
    .step_count (step_count),
    .out_valid  (f_valid),
    .out_item   (f_item)
  );

  // queue parts decode from compute; the back drains it every cycle
  assign q_pop = !q_stat.empty;

  uvs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  // back: trig lookups, products, output register
  uvs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (q_pop),
    .in_item            (q_head),
    .radius             (sphere_radius),
    .done               (done),
    .pos_x              (pos_x),
    .pos_y              (pos_y),
    .pos_z              (pos_z),
    .tex_s              (tex_s),
    .tex_t              (tex_t),
    .norm_x             (norm_x),
    .norm_y             (norm_y),
    .norm_z             (norm_z),
    .index_out_of_range (index_out_of_range),
    .final_vertex       (final_vertex)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(uvs_pkg::LATENCY) done)
    else $error("item did not complete in the expected latency");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    !(f_valid && q_stat.full))
    else $error("decoded item pushed into a full queue");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(index_out_of_range && final_vertex))
    else $error("final vertex flagged on an out-of-range index");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && index_out_of_range |-> pos_y == '0 && norm_y == '0 && tex_t == '0)
    else $error("out-of-range result carries nonzero fields");

endmodule
